/* src/circular_deque_assert.svh */
// assertion macros used by the checker file
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define CDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define CDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg
// shared constants, types and index helpers for the ring deque
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = 6;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY      = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam idx_t IDX_LAST = idx_t'(DEPTH - 1);

  // ring successor
  function automatic idx_t idx_next(input idx_t i);
    idx_next = (i == IDX_LAST) ? '0 : idx_t'(i + 1'b1);
  endfunction

  // ring predecessor
  function automatic idx_t idx_prev(input idx_t i);
    idx_prev = (i == '0) ? IDX_LAST : idx_t'(i - 1'b1);
  endfunction

endpackage

`default_nettype wire

/* src/cdq_ram.sv */
// ----------------------------------------------------------------------------
// cdq_ram
// simple dual-port ring store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
  parameter int WORDS = 32,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(WORDS)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(WORDS)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [WORDS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/circular_deque.sv */
// ----------------------------------------------------------------------------
// circular_deque
// fixed-depth double-ended queue kept in a ring memory
// ----------------------------------------------------------------------------
// Usage:
//   in_ channel carries one command per transaction (query, push back, push
//   front, pop front, pop back) with the word to push. out_ channel returns
//   exactly one result per transaction: status, popped word, front and back
//   words, element count and empty/full flags as they stand after the step.
//   A transaction is taken on an edge where valid is high and stall is low.
// Timing:
//   each command has an accept step and an update step: the accept cycle
//   issues one read of the ring memory (next front or new back entry) and
//   the update stage uses the registered read data to update the indices and
//   load the output register. out_valid is registered and is set at the edge
//   that ends the update stage. A new command is accepted only after the last
//   one has left the update stage, since in_stall is high throughout it.
// Stalls:
//   the output register holds a finished result while out_stall is high; a
//   new command is still accepted, and its result waits in the update stage
//   with in_stall high until the output register is free.
// Reset:
//   rst_n low empties the deque (indices zero, empty set) and drops any
//   pending result; memory contents are not cleared, only held entries read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module circular_deque
  import cdq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic [31:0]         in_push_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [STAT_W-1:0]   out_status,
  output logic      [31:0]         out_popped_value,
  output logic      [31:0]         out_front_value,
  output logic      [31:0]         out_back_value,
  output logic      [CNT_W-1:0]    out_count,
  output logic                     out_empty_flag,
  output logic                     out_full_flag
);

  typedef enum logic {
    S_ACCEPT,
    S_UPDATE
  } state_t;

  state_t          state_r;
  logic [CMD_W-1:0] cmd_r;
  data_t           word_r;
  idx_t            front_r, rear_r;
  logic            empty_r;
  data_t           fval_r, bval_r;
  logic            out_valid_r;

  logic            in_take, slot_free, finish;
  logic            rd_en;
  idx_t            rd_addr;
  data_t           rd_data;
  logic            wr_en;
  idx_t            wr_addr;

  logic            full_now;
  idx_t            front_nxt, rear_nxt;
  logic            empty_nxt, full_nxt;
  data_t           fval_nxt, bval_nxt, popped_nxt;
  status_t         status_nxt;
  cnt_t            count_nxt;

  assign in_stall  = (state_r != S_ACCEPT);
  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign finish    = (state_r == S_UPDATE) && slot_free;

  // read address for the entry that becomes the new front or back
  always_comb begin
    rd_en   = in_take;
    rd_addr = idx_next(front_r);
    if (in_command == CMD_POP_BACK) begin
      rd_addr = idx_prev(idx_prev(rear_r));
    end
  end

  cdq_ram #(
    .WORDS (DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (word_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // step of the deque for the latched command
  always_comb begin
    full_now   = !empty_r && (front_r == rear_r);
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    empty_nxt  = empty_r;
    fval_nxt   = fval_r;
    bval_nxt   = bval_r;
    popped_nxt = '0;
    status_nxt = ST_OK;
    wr_en      = 1'b0;
    wr_addr    = rear_r;
    case (cmd_r)
      CMD_PUSH_BACK: begin
        if (full_now) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = finish;
          wr_addr   = rear_r;
          rear_nxt  = idx_next(rear_r);
          empty_nxt = 1'b0;
          bval_nxt  = word_r;
          if (empty_r) begin
            fval_nxt = word_r;
          end
        end
      end
      CMD_PUSH_FRONT: begin
        if (full_now) begin
          status_nxt = ST_FULL;
        end else begin
          front_nxt = idx_prev(front_r);
          wr_en     = finish;
          wr_addr   = idx_prev(front_r);
          empty_nxt = 1'b0;
          fval_nxt  = word_r;
          if (empty_r) begin
            bval_nxt = word_r;
          end
        end
      end
      CMD_POP_FRONT: begin
        if (empty_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt = fval_r;
          front_nxt  = idx_next(front_r);
          empty_nxt  = (idx_next(front_r) == rear_r);
          fval_nxt   = rd_data;
        end
      end
      CMD_POP_BACK: begin
        if (empty_r) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt = bval_r;
          rear_nxt   = idx_prev(rear_r);
          empty_nxt  = (idx_prev(rear_r) == front_r);
          bval_nxt   = rd_data;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    full_nxt = !empty_nxt && (front_nxt == rear_nxt);
    if (empty_nxt) begin
      count_nxt = '0;
    end else if (full_nxt) begin
      count_nxt = cnt_t'(DEPTH);
    end else if (rear_nxt > front_nxt) begin
      count_nxt = cnt_t'(rear_nxt - front_nxt);
    end else begin
      count_nxt = cnt_t'(DEPTH) - cnt_t'(front_nxt) + cnt_t'(rear_nxt);
    end
  end

  // sequencer, deque state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACCEPT;
      front_r     <= '0;
      rear_r      <= '0;
      empty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: set on finish, cleared when the result is taken
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_ACCEPT: begin
          if (in_take) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (slot_free) begin
            state_r <= S_ACCEPT;
            front_r <= front_nxt;
            rear_r  <= rear_nxt;
            empty_r <= empty_nxt;
          end
        end
        default: begin
          state_r <= S_ACCEPT;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= in_command;
      word_r <= in_push_value;
    end
    if (finish) begin
      fval_r           <= fval_nxt;
      bval_r           <= bval_nxt;
      out_status       <= status_nxt;
      out_popped_value <= popped_nxt;
      out_front_value  <= empty_nxt ? '0 : fval_nxt;
      out_back_value   <= empty_nxt ? '0 : bval_nxt;
      out_count        <= count_nxt;
      out_empty_flag   <= empty_nxt;
      out_full_flag    <= full_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* src/cdq_checker.sv */
// ----------------------------------------------------------------------------
// cdq_checker
// port-level checks on the deque, bound onto the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "circular_deque_assert.svh"

module cdq_checker
  import cdq_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic [31:0]       out_popped_value,
  input wire logic [31:0]       out_front_value,
  input wire logic [31:0]       out_back_value,
  input wire logic [CNT_W-1:0]  out_count,
  input wire logic              out_empty_flag,
  input wire logic              out_full_flag
);

  logic in_fire;

  assign in_fire = in_valid && !in_stall;

  // one transaction in flight: no accept in the cycle after an accept
  `CDQ_ASSERT_NEXT(a_one_in_flight, in_fire, in_stall, "accept right after accept")

  // an empty result shows zero count and zero end words
  `CDQ_ASSERT_NOW(a_empty_zero, out_valid && out_empty_flag,
    out_count == '0 && out_front_value == '0 && out_back_value == '0 && !out_full_flag,
    "empty result with data")

  // a full result carries the whole depth
  `CDQ_ASSERT_NOW(a_full_count, out_valid && out_full_flag,
    out_count == cnt_t'(DEPTH) && !out_empty_flag, "full result with wrong count")

  // a refused command pops nothing
  `CDQ_ASSERT_NOW(a_refused_zero, out_valid && out_status != ST_OK,
    out_popped_value == '0, "refused command popped a word")

  // a stalled result holds
  `CDQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_popped_value) && $stable(out_status) && $stable(out_count),
    "stalled result changed")

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);

`default_nettype wire
